// ----- hdl/rpa_pkg.sv -----
// Package with the types, sizes and codes shared by the page allocator files.
`timescale 1ns / 1ps
`default_nettype none
package rpa_pkg;

    // Size of the managed region in pages.
    localparam int NUM_PAGES = 32768;
    localparam int IDX_W     = $clog2(NUM_PAGES);
    localparam int TOP_W     = IDX_W + 1;
    localparam int PAGE_W    = 28;
    localparam int CNT_W     = 16;
    localparam int FREE_W    = 16;
    localparam int FUNC_W    = 2;
    localparam int STAT_W    = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register addresses on the configuration port.
    localparam logic [1:0] REG_REGION_BASE = 2'd0;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADDREF = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_RANGE  = 3'd2;
    localparam logic [STAT_W-1:0] ST_DOUBLE = 3'd3;
    localparam logic [STAT_W-1:0] ST_SAT    = 3'd4;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [PAGE_W-1:0] page_number;
    } rpa_cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PAGE_W-1:0] alloc_page;
        logic [FREE_W-1:0] free_count;
        logic [CNT_W-1:0]  count_after;
    } rpa_rsp_t;

    // One word of the per-page memory.
    typedef struct packed {
        logic             on_stack;
        logic [CNT_W-1:0] count;
    } rpa_entry_t;

    // Write request to the per-page memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        rpa_entry_t       data;
    } rpa_page_wr_t;

    // Control of the free stack.
    typedef struct packed {
        logic             rd;
        logic             pop;
        logic             push;
        logic [IDX_W-1:0] push_idx;
    } rpa_stack_ctl_t;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } rpa_state_t;

endpackage
`default_nettype wire

// ----- hdl/rpa_page_mem.sv -----
// Per-page memory holding the reference count and the on-stack flag, with its clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module rpa_page_mem (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      rd_en,
    input  wire logic [rpa_pkg::IDX_W-1:0] rd_addr,
    output rpa_pkg::rpa_entry_t            rd_data,
    input  wire rpa_pkg::rpa_page_wr_t     wr,
    output logic                           clearing
);

    rpa_pkg::rpa_entry_t mem [rpa_pkg::NUM_PAGES];

    logic [rpa_pkg::IDX_W-1:0] clr_cnt_reg;
    logic [rpa_pkg::IDX_W-1:0] clr_cnt_next;
    logic                      clearing_reg;
    logic                      clearing_next;

    // Every entry is written to zero once after reset, one per cycle.
    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == rpa_pkg::IDX_W'(rpa_pkg::NUM_PAGES - 1))
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clearing_reg <= clearing_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clearing = clearing_reg;

endmodule
`default_nettype wire

// ----- hdl/rpa_free_stack.sv -----
// Free-page stack: memory of page indices and the stack top pointer.
`timescale 1ns / 1ps
`default_nettype none
module rpa_free_stack (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire rpa_pkg::rpa_stack_ctl_t   ctl,
    output logic [rpa_pkg::TOP_W-1:0]      top,
    output logic [rpa_pkg::IDX_W-1:0]      rd_idx
);

    logic [rpa_pkg::IDX_W-1:0] mem [rpa_pkg::NUM_PAGES];

    logic [rpa_pkg::TOP_W-1:0] top_reg;
    logic [rpa_pkg::TOP_W-1:0] top_next;
    logic [rpa_pkg::TOP_W-1:0] top_dec;

    assign top_dec = top_reg - 1'b1;

    always_comb
    begin
        priority if (ctl.pop)
        begin
            top_next = top_dec;
        end
        else if (ctl.push)
        begin
            top_next = top_reg + 1'b1;
        end
        else
        begin
            top_next = top_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg <= '0;
        end
        else
        begin
            top_reg <= top_next;
        end
    end

    // The read fetches the entry below the top, ready for a pop in the next cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.rd)
        begin
            rd_idx <= mem[top_dec[rpa_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.push)
        begin
            mem[top_reg[rpa_pkg::IDX_W-1:0]] <= ctl.push_idx;
        end
    end

    assign top = top_reg;

endmodule
`default_nettype wire

// ----- hdl/refcounted_page_allocator.sv -----
// Top level of the reference-counted page allocator with its register port and sequencer.
// A request accepted in IDLE is handled in the EXEC state; its result is then registered
// onto the result ports, marked by done, which is high for the one cycle. busy stays high
// during the EXEC state, the read-modify-write of the per-page memory, so a new request is
// not taken until the last one is through it. After reset a clearing pass zeroes every
// page entry; busy is high for the pass and until the sequencer leaves its CLEAR state.
// Register writes are taken throughout.
`timescale 1ns / 1ps
`default_nettype none
module refcounted_page_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Request channel.
    input  wire logic        start,
    output logic             busy,
    input  wire rpa_pkg::rpa_cmd_t cmd,
    // Result channel; the receiver cannot hold a result off.
    output logic             done,
    output rpa_pkg::rpa_rsp_t result,
    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // ------------------------------------------------------------------
    // Register port. There is a single register, at address zero; reads
    // return it whatever the address.
    // ------------------------------------------------------------------
    logic [rpa_pkg::PAGE_W-1:0] base_reg;
    logic                       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {{(32 - rpa_pkg::PAGE_W){1'b0}}, base_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= rpa_pkg::PAGE_W'(524288);
        end
        else if (cfg_wr && (paddr == rpa_pkg::REG_REGION_BASE))
        begin
            base_reg <= pwdata[rpa_pkg::PAGE_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. A transaction is accepted in IDLE; the memory reads are
    // issued at that same edge, and the EXEC cycle then sees the read
    // data, computes the new entry, writes it back and registers the result.
    // Because the write-back happens before the next request can be taken,
    // back-to-back accesses to the same page need no forwarding.
    // ------------------------------------------------------------------
    rpa_pkg::rpa_state_t state_reg;
    rpa_pkg::rpa_state_t state_next;

    logic accept;
    logic clearing;

    assign busy   = (state_reg != rpa_pkg::S_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        unique case (state_reg)
            rpa_pkg::S_CLEAR: state_next = clearing ? rpa_pkg::S_CLEAR : rpa_pkg::S_IDLE;
            rpa_pkg::S_IDLE:  state_next = accept ? rpa_pkg::S_EXEC : rpa_pkg::S_IDLE;
            rpa_pkg::S_EXEC:  state_next = rpa_pkg::S_IDLE;
            default:          state_next = rpa_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Region check. The page index wraps modulo the page-number space, so a
    // page below the base gives a large index and falls outside the region.
    // ------------------------------------------------------------------
    logic [rpa_pkg::PAGE_W-1:0] diff;
    logic                       in_range;

    assign diff     = cmd.page_number - base_reg;
    assign in_range = (diff < rpa_pkg::PAGE_W'(rpa_pkg::NUM_PAGES));

    // Request fields held for the EXEC cycle.
    logic [rpa_pkg::FUNC_W-1:0] func_reg;
    logic [rpa_pkg::IDX_W-1:0]  idx_reg;
    logic                       in_range_reg;
    logic                       empty_reg;

    logic [rpa_pkg::TOP_W-1:0]  top;
    logic [rpa_pkg::IDX_W-1:0]  stack_idx;
    rpa_pkg::rpa_entry_t        entry;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= cmd.func;
            idx_reg      <= diff[rpa_pkg::IDX_W-1:0];
            in_range_reg <= in_range;
            empty_reg    <= (top == '0);
        end
    end

    // ------------------------------------------------------------------
    // Memories.
    // ------------------------------------------------------------------
    rpa_pkg::rpa_page_wr_t   page_wr;
    rpa_pkg::rpa_stack_ctl_t stack_ctl;
    rpa_pkg::rpa_stack_ctl_t exec_ctl;

    rpa_page_mem u_page_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_addr  (diff[rpa_pkg::IDX_W-1:0]),
        .rd_data  (entry),
        .wr       (page_wr),
        .clearing (clearing)
    );

    // The stack read for an allocate is issued at acceptance, the pop or push
    // comes from the EXEC cycle.
    always_comb
    begin
        stack_ctl    = exec_ctl;
        stack_ctl.rd = accept && (cmd.func == rpa_pkg::FUNC_ALLOC) && (top != '0);
    end

    rpa_free_stack u_free_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (stack_ctl),
        .top    (top),
        .rd_idx (stack_idx)
    );

    // ------------------------------------------------------------------
    // Read-modify-write of the page entry and the result.
    // ------------------------------------------------------------------
    rpa_pkg::rpa_rsp_t          rsp_next;
    rpa_pkg::rpa_rsp_t          rsp_reg;
    logic                       done_reg;
    logic [rpa_pkg::CNT_W-1:0]  cnt_dec;
    logic                       push;
    logic [rpa_pkg::TOP_W-1:0]  top_dec;
    logic [rpa_pkg::TOP_W-1:0]  top_inc;

    assign cnt_dec = (entry.count == '0) ? '0 : entry.count - 1'b1;
    assign push    = (cnt_dec == '0) && (top < rpa_pkg::TOP_W'(rpa_pkg::NUM_PAGES));
    assign top_dec = top - 1'b1;
    assign top_inc = top + 1'b1;

    always_comb
    begin
        page_wr              = '0;
        page_wr.addr         = idx_reg;
        exec_ctl             = '0;
        exec_ctl.push_idx    = idx_reg;
        rsp_next             = '0;
        rsp_next.status      = rpa_pkg::ST_OK;
        rsp_next.free_count  = rpa_pkg::FREE_W'(top);

        if (state_reg == rpa_pkg::S_EXEC)
        begin
            unique case (func_reg)
                rpa_pkg::FUNC_ALLOC:
                begin
                    if (empty_reg)
                    begin
                        rsp_next.status = rpa_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        exec_ctl.pop           = 1'b1;
                        page_wr.we             = 1'b1;
                        page_wr.addr           = stack_idx;
                        page_wr.data.on_stack  = 1'b0;
                        page_wr.data.count     = rpa_pkg::CNT_W'(1);
                        rsp_next.alloc_page    = base_reg +
                            {{(rpa_pkg::PAGE_W - rpa_pkg::IDX_W){1'b0}}, stack_idx};
                        rsp_next.count_after   = rpa_pkg::CNT_W'(1);
                        rsp_next.free_count    = rpa_pkg::FREE_W'(top_dec);
                    end
                end
                rpa_pkg::FUNC_FREE:
                begin
                    if (!in_range_reg)
                    begin
                        rsp_next.status = rpa_pkg::ST_RANGE;
                    end
                    else if (entry.on_stack)
                    begin
                        rsp_next.status      = rpa_pkg::ST_DOUBLE;
                        rsp_next.count_after = entry.count;
                    end
                    else
                    begin
                        // A zero count stays zero and the page is pushed.
                        page_wr.we            = 1'b1;
                        page_wr.data.on_stack = push;
                        page_wr.data.count    = cnt_dec;
                        exec_ctl.push         = push;
                        rsp_next.count_after  = cnt_dec;
                        if (push)
                        begin
                            rsp_next.free_count = rpa_pkg::FREE_W'(top_inc);
                        end
                    end
                end
                rpa_pkg::FUNC_ADDREF:
                begin
                    if (!in_range_reg)
                    begin
                        rsp_next.status = rpa_pkg::ST_RANGE;
                    end
                    else if (entry.count == rpa_pkg::COUNT_MAX)
                    begin
                        rsp_next.status      = rpa_pkg::ST_SAT;
                        rsp_next.count_after = rpa_pkg::COUNT_MAX;
                    end
                    else
                    begin
                        page_wr.we            = 1'b1;
                        page_wr.data.on_stack = entry.on_stack;
                        page_wr.data.count    = entry.count + 1'b1;
                        rsp_next.count_after  = entry.count + 1'b1;
                    end
                end
                rpa_pkg::FUNC_QUERY:
                begin
                    rsp_next.status = rpa_pkg::ST_OK;
                end
                default:
                begin
                    rsp_next.status = rpa_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == rpa_pkg::S_EXEC);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == rpa_pkg::S_EXEC)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done   = done_reg;
    assign result = rsp_reg;

endmodule
`default_nettype wire

// ----- hdl/rpa_checker.sv -----
// Port-level checker for the page allocator and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rpa_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              done,
    input wire rpa_pkg::rpa_rsp_t result
);

    // An accepted transaction holds off the next one in the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted transaction");

    // Every accepted transaction passes through the EXEC state and then raises done.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after acceptance");

    // A result only follows a cycle in which the block was working.
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a transaction in progress");

    // Status codes stay within the defined set.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status <= rpa_pkg::ST_SAT))
        else $error("undefined status code");

    // An allocate from an empty stack hands nothing out.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == rpa_pkg::ST_EMPTY)) |->
        ((result.alloc_page == '0) && (result.count_after == '0) &&
         (result.free_count == '0)))
        else $error("empty allocate returned a page");

endmodule

bind refcounted_page_allocator rpa_checker u_rpa_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

// ----- bench/rpa_ledger_pkg.sv -----
// Scoreboard class that predicts and checks the page allocator's results.
`timescale 1ns / 1ps
package rpa_ledger_pkg;
    import rpa_pkg::*;

    localparam logic [PAGE_W-1:0] REGION_BASE_RESET = 28'd524288;

    class alloc_ledger;
        bit [CNT_W-1:0]  counts    [NUM_PAGES];
        bit              on_stack  [NUM_PAGES];
        bit [IDX_W-1:0]  free_list [NUM_PAGES];
        int unsigned     depth;
        bit [PAGE_W-1:0] base_page;
        rpa_rsp_t        expected_rsps [$];
        int              errors;

        function new();
            depth     = 0;
            base_page = REGION_BASE_RESET;
            errors    = 0;
        endfunction

        function void set_base(logic [PAGE_W-1:0] value);
            base_page = value;
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

        // Applies one accepted request to the mirrored state and queues its result.
        function void note_request(rpa_cmd_t req);
            rpa_rsp_t        want;
            logic [PAGE_W-1:0] offset;
            logic [IDX_W-1:0]  idx;
            logic              in_region;
            want      = '0;
            offset    = req.page_number - base_page;
            idx       = offset[IDX_W-1:0];
            in_region = (offset < NUM_PAGES);
            case (req.func)
                FUNC_ALLOC:
                begin
                    if (depth == 0)
                    begin
                        want.status = ST_EMPTY;
                    end
                    else
                    begin
                        depth--;
                        idx = free_list[depth];
                        on_stack[idx]    = 1'b0;
                        counts[idx]      = CNT_W'(1);
                        want.alloc_page  = base_page + PAGE_W'(idx);
                        want.count_after = CNT_W'(1);
                    end
                end
                FUNC_FREE:
                begin
                    if (!in_region)
                    begin
                        want.status = ST_RANGE;
                    end
                    else if (on_stack[idx])
                    begin
                        want.status      = ST_DOUBLE;
                        want.count_after = counts[idx];
                    end
                    else
                    begin
                        if (counts[idx] != 0)
                            counts[idx] = counts[idx] - 1'b1;
                        if (counts[idx] == 0)
                        begin
                            free_list[depth] = idx;
                            depth++;
                            on_stack[idx] = 1'b1;
                        end
                        want.count_after = counts[idx];
                    end
                end
                FUNC_ADDREF:
                begin
                    if (!in_region)
                    begin
                        want.status = ST_RANGE;
                    end
                    else
                    begin
                        if (counts[idx] == COUNT_MAX)
                            want.status = ST_SAT;
                        else
                            counts[idx] = counts[idx] + 1'b1;
                        want.count_after = counts[idx];
                    end
                end
                default:
                begin
                end
            endcase
            want.status     = (want.status);
            want.free_count = FREE_W'(depth);
            expected_rsps.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(rpa_rsp_t got);
            rpa_rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                errors++;
                $display("%0t: result with none outstanding, expected nothing, got %h",
                         $time, got);
                return;
            end
            want = expected_rsps.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("alloc_page", 32'(want.alloc_page), 32'(got.alloc_page));
            compare_field("free_count", 32'(want.free_count), 32'(got.free_count));
            compare_field("count_after", 32'(want.count_after), 32'(got.count_after));
        endfunction
    endclass

endpackage

// ----- bench/refcounted_page_allocator_test.sv -----
// Self-checking testbench for the reference-counted page allocator.
`timescale 1ns / 1ps
module refcounted_page_allocator_test;
    import rpa_pkg::*;
    import rpa_ledger_pkg::*;

    // A normal run ends before the cycle limit is reached, most of its cycles spent in the
    // clearing pass after reset.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int PHASE_ITEMS  = 610;
    localparam int WORKING_SET  = 48;
    localparam int TAIL_CYCLES  = 6;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    rpa_cmd_t    cmd     = '0;
    logic        done;
    rpa_rsp_t    result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    alloc_ledger     ledger;
    logic [PAGE_W-1:0] base_page  = REGION_BASE_RESET;
    int              idle_pct   = 0;
    int              burst_left = 0;
    int              cycle_count = 0;

    refcounted_page_allocator uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Results are strobed for a single cycle and cannot be held off, so every rising
    // edge with done high carries one transaction for the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && done)
            ledger.check_result(result);
    end

    // Watchdog: a hung handshake or a lost result ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic rpa_cmd_t make_req(logic [FUNC_W-1:0] func, logic [PAGE_W-1:0] page);
        rpa_cmd_t req;
        req.func        = func;
        req.page_number = page;
        return req;
    endfunction

    // Number of idle cycles the sender inserts before its next request. Now and then
    // a burst of back-to-back requests is thrown in so that stretches without gaps also
    // occur in the phases that insert idle cycles.
    function automatic int idle_gap();
        int n;
        n = 0;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else if ($urandom_range(0, 63) == 0)
        begin
            burst_left = 16;
        end
        else
        begin
            while ($urandom_range(0, 99) < idle_pct)
                n++;
        end
        return n;
    endfunction

    // Mostly well-formed traffic on a small working set of pages, so that frees,
    // allocations, double frees and reference counts above one all keep recurring.
    // The remainder probes the region boundaries or is fully random noise.
    function automatic rpa_cmd_t pick_request();
        rpa_cmd_t req;
        int       roll;
        int       op_roll;
        int       idx;
        req.func        = FUNC_W'($urandom_range(0, 3));
        req.page_number = PAGE_W'($urandom);
        roll            = $urandom_range(0, 99);
        if (roll < 70)
        begin
            op_roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0)
                idx = $urandom_range(0, NUM_PAGES - 1);
            else
                idx = $urandom_range(0, WORKING_SET - 1);
            if (op_roll < 25)
                req.func = FUNC_ALLOC;
            else if (op_roll < 60)
                req.func = FUNC_FREE;
            else if (op_roll < 85)
                req.func = FUNC_ADDREF;
            else
                req.func = FUNC_QUERY;
            if (req.func == FUNC_FREE || req.func == FUNC_ADDREF)
                req.page_number = base_page + PAGE_W'(idx);
        end
        else if (roll < 82)
        begin
            req.func = ($urandom_range(0, 1) == 0) ? FUNC_FREE : FUNC_ADDREF;
            case ($urandom_range(0, 3))
                0: req.page_number = base_page - 1'b1;
                1: req.page_number = base_page + PAGE_W'(NUM_PAGES);
                2: req.page_number = base_page + PAGE_W'(NUM_PAGES - 1);
                default: req.page_number = base_page;
            endcase
        end
        return req;
    endfunction

    // Drives one request after the given number of idle cycles and returns once the
    // transaction has been accepted, at which point the scoreboard is told about it.
    task automatic issue(input rpa_cmd_t req, input int gap);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
            cmd   <= {FUNC_W'($urandom), PAGE_W'($urandom)};
        end
        @(negedge clk);
        start <= 1'b1;
        cmd   <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        ledger.note_request(req);
    endtask

    // Stops issuing and waits until every outstanding result has come back.
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (ledger.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);
    endtask

    // Register write with a setup phase and then an access phase; pready is honoured even though
    // the block always holds it high.
    task automatic write_region_base(input logic [PAGE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_REGION_BASE;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        base_page = value;
        ledger.set_base(value);
    endtask

    initial
    begin
        ledger = new();

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with the region at its reset position. The block is still in
        // its clearing pass here; the first request simply waits for busy to fall.
        idle_pct = 26;
        issue(make_req(FUNC_ALLOC,  '0), 0);                               // empty stack
        issue(make_req(FUNC_QUERY,  28'h5A5A5A5), idle_gap());
        issue(make_req(FUNC_FREE,   base_page), idle_gap());               // seed index 0
        issue(make_req(FUNC_FREE,   base_page + 1'b1), idle_gap());
        issue(make_req(FUNC_FREE,   base_page + PAGE_W'(NUM_PAGES - 1)), idle_gap());
        issue(make_req(FUNC_FREE,   base_page - 1'b1), idle_gap());        // just below
        issue(make_req(FUNC_FREE,   base_page + PAGE_W'(NUM_PAGES)), idle_gap());
        issue(make_req(FUNC_FREE,   base_page), idle_gap());               // double free
        issue(make_req(FUNC_ADDREF, base_page + 1'b1), idle_gap());        // while stacked
        issue(make_req(FUNC_FREE,   base_page + 1'b1), idle_gap());        // still stacked
        issue(make_req(FUNC_ALLOC,  '1), idle_gap());                      // page ignored
        issue(make_req(FUNC_ALLOC,  '0), idle_gap());
        issue(make_req(FUNC_ADDREF, base_page + 1'b1), idle_gap());
        issue(make_req(FUNC_FREE,   base_page + 1'b1), idle_gap());        // count above one
        issue(make_req(FUNC_FREE,   base_page + 1'b1), idle_gap());        // back to the stack
        issue(make_req(FUNC_ADDREF, base_page - 1'b1), idle_gap());
        issue(make_req(FUNC_ADDREF, '1), idle_gap());
        issue(make_req(FUNC_FREE,   '0), idle_gap());
        issue(make_req(FUNC_QUERY,  '1), idle_gap());
        issue(make_req(FUNC_ALLOC,  '0), idle_gap());
        issue(make_req(FUNC_ALLOC,  '0), idle_gap());
        issue(make_req(FUNC_ALLOC,  '0), idle_gap());                      // empty again
        drain();

        // Random phases. Each moves the region: to the bottom of the page space, to
        // the very top so that all but one index wraps round, and to a position where
        // the region straddles the top of the page space.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct = 26;
                    write_region_base('0);
                end
                1:
                begin
                    idle_pct = 82;
                    write_region_base('1);
                end
                default:
                begin
                    idle_pct = 0;
                    write_region_base(28'hFFFF000);
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                issue(pick_request(), idle_gap());
            drain();
        end

        if (ledger.errors == 0 && ledger.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/rpa_pkg.sv
hdl/rpa_page_mem.sv
hdl/rpa_free_stack.sv
hdl/refcounted_page_allocator.sv
hdl/rpa_checker.sv
bench/rpa_ledger_pkg.sv
bench/refcounted_page_allocator_test.sv
